### hw/rtl/tid_pkg.sv
// Shared codes and helpers for the TPM I2C transaction decoder.
`default_nettype none

package tid_pkg;

  typedef logic [3:0] kind_t;
  typedef logic [1:0] op_t;
  typedef logic [1:0] rec_kind_t;
  typedef logic [1:0] warn_code_t;

  // I2C event kinds
  localparam kind_t KIND_START      = 4'd0;
  localparam kind_t KIND_REPEAT     = 4'd1;
  localparam kind_t KIND_STOP       = 4'd2;
  localparam kind_t KIND_ADDR_READ  = 4'd3;
  localparam kind_t KIND_ADDR_WRITE = 4'd4;
  localparam kind_t KIND_DATA_READ  = 4'd5;
  localparam kind_t KIND_DATA_WRITE = 4'd6;
  localparam kind_t KIND_ACK        = 4'd7;
  localparam kind_t KIND_NACK       = 4'd8;
  localparam kind_t KIND_BITS       = 4'd9;

  // Output record kinds
  localparam rec_kind_t REC_ADDR = 2'd0;
  localparam rec_kind_t REC_DATA = 2'd1;
  localparam rec_kind_t REC_END  = 2'd2;
  localparam rec_kind_t REC_WARN = 2'd3;

  // Warning codes: what the machine expected
  localparam warn_code_t WARN_REG_ADDR     = 2'd0;
  localparam warn_code_t WARN_WAIT_OP      = 2'd1;
  localparam warn_code_t WARN_ADDR_READ    = 2'd2;
  localparam warn_code_t WARN_WRITE_BURST  = 2'd3;

  // Commands passed from front to back
  localparam op_t OP_ADDR  = 2'd0;
  localparam op_t OP_WARN  = 2'd1;
  localparam op_t OP_STORE = 2'd2;
  localparam op_t OP_DUMP  = 2'd3;

  // Command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Packed command width: op, is_read, reg, data, count, warn, kind, three stamps
  function automatic int cmd_width(input int cnt_w, input int stamp_w);
    return 25 + cnt_w + 3 * stamp_w;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tid_channels.sv
// Valid/ready channel interfaces for I2C events and decoded records.
`default_nettype none

interface tid_ev_if #(
  parameter int STAMP_WIDTH = 48
);
  logic                   valid;
  logic                   ready;
  logic [3:0]             kind;
  logic [7:0]             data_byte;
  logic [STAMP_WIDTH-1:0] start_stamp;
  logic [STAMP_WIDTH-1:0] end_stamp;

  modport source (output valid, kind, data_byte, start_stamp, end_stamp, input ready);
  modport sink (input valid, kind, data_byte, start_stamp, end_stamp, output ready);
endinterface

interface tid_rec_if #(
  parameter int STAMP_WIDTH = 48,
  parameter int IDX_W       = 5,
  parameter int CNT_W       = 6
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             record_kind;
  logic                   is_read;
  logic [7:0]             reg_address;
  logic [7:0]             out_byte;
  logic [IDX_W-1:0]       byte_index;
  logic [CNT_W-1:0]       byte_count;
  logic [1:0]             warning_code;
  logic [3:0]             got_kind;
  logic [STAMP_WIDTH-1:0] span_start;
  logic [STAMP_WIDTH-1:0] span_end;
  logic                   last;

  modport source (
    output valid, record_kind, is_read, reg_address, out_byte, byte_index, byte_count,
           warning_code, got_kind, span_start, span_end, last,
    input  ready
  );
  modport sink (
    input  valid, record_kind, is_read, reg_address, out_byte, byte_index, byte_count,
           warning_code, got_kind, span_start, span_end, last,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/tid_queue.sv
// Small register FIFO carrying commands from the front to the back.
`default_nettype none

module tid_queue
  import tid_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head,
  output logic                  full,
  output logic                  empty
);

  logic [WIDTH-1:0]  slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command queue underflow");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue fill out of range");

endmodule

`default_nettype wire

### hw/rtl/tid_front.sv
// Front end: accepts I2C events, tracks the transaction phase, issues commands.
`default_nettype none

module tid_front
  import tid_pkg::*;
#(
  parameter int BUFFER_DEPTH = 32,
  parameter int STAMP_WIDTH  = 48,
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1),
  localparam int CMD_W = cmd_width(CNT_W, STAMP_WIDTH)
) (
  input  wire logic    clk,
  input  wire logic    rst,
  tid_ev_if.sink       ev,
  input  wire logic    q_full,
  output logic         push,
  output logic [CMD_W-1:0] cmd
);

  typedef struct packed {
    op_t                    op;
    logic                   is_read;
    logic [7:0]             reg_address;
    logic [7:0]             data;
    logic [CNT_W-1:0]       count;
    warn_code_t             warning_code;
    kind_t                  got_kind;
    logic [STAMP_WIDTH-1:0] stamp_a;
    logic [STAMP_WIDTH-1:0] stamp_b;
    logic [STAMP_WIDTH-1:0] stamp_c;
  } cmd_t;

  localparam logic [3:0] P_IDLE           = 4'd0;
  localparam logic [3:0] P_ADDR_WRITE     = 4'd1;
  localparam logic [3:0] P_ADDR_ACK       = 4'd2;
  localparam logic [3:0] P_REG_ADDR       = 4'd3;
  localparam logic [3:0] P_REG_ADDR_ACK   = 4'd4;
  localparam logic [3:0] P_WAIT_OP        = 4'd5;
  localparam logic [3:0] P_READ_ADDR      = 4'd6;
  localparam logic [3:0] P_READ_ADDR_ACK  = 4'd7;
  localparam logic [3:0] P_READ_DATA      = 4'd8;
  localparam logic [3:0] P_WRITE_DATA     = 4'd9;
  localparam logic [3:0] P_WRITE_DATA_ACK = 4'd10;

  logic [3:0]             phase, phase_next;
  logic [7:0]             reg_addr, reg_addr_next;
  logic                   reading, reading_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [STAMP_WIDTH-1:0] addr_stamp, addr_stamp_next;
  logic [STAMP_WIDTH-1:0] data_stamp, data_stamp_next;
  logic                   accept;
  logic                   room;
  cmd_t                   c;

  assign ev.ready = !q_full;
  assign accept   = ev.valid && ev.ready;
  assign room     = (count < CNT_W'(BUFFER_DEPTH));
  assign cmd      = c;

  // phase machine and command build
  always_comb begin
    phase_next      = phase;
    reg_addr_next   = reg_addr;
    reading_next    = reading;
    count_next      = count;
    addr_stamp_next = addr_stamp;
    data_stamp_next = data_stamp;
    push            = 1'b0;
    c               = '0;
    c.stamp_a       = ev.start_stamp;
    c.stamp_c       = ev.end_stamp;
    c.got_kind      = ev.kind;
    c.data          = ev.data_byte;
    c.count         = count;

    if (accept && ev.kind != KIND_BITS) begin
      case (phase)
        P_IDLE: begin
          if (ev.kind == KIND_START) begin
            phase_next = P_ADDR_WRITE;
            count_next = '0;
          end
        end
        P_ADDR_WRITE: begin
          if (ev.kind == KIND_ADDR_WRITE) begin
            addr_stamp_next = ev.start_stamp;
            phase_next      = P_ADDR_ACK;
          end else begin
            phase_next = P_IDLE;
          end
        end
        P_ADDR_ACK, P_REG_ADDR_ACK, P_READ_ADDR_ACK, P_WRITE_DATA_ACK: begin
          if (ev.kind == KIND_ACK) begin
            case (phase)
              P_ADDR_ACK:      phase_next = P_REG_ADDR;
              P_REG_ADDR_ACK:  phase_next = P_WAIT_OP;
              P_READ_ADDR_ACK: phase_next = P_READ_DATA;
              default:         phase_next = P_WRITE_DATA;
            endcase
          end else if (ev.kind == KIND_NACK) begin
            phase_next = P_IDLE;
          end
        end
        P_REG_ADDR: begin
          push = 1'b1;
          if (ev.kind == KIND_DATA_WRITE) begin
            reg_addr_next = ev.data_byte;
            c.op          = OP_ADDR;
            c.reg_address = ev.data_byte;
            c.got_kind    = '0;
            c.stamp_a     = addr_stamp;
            phase_next    = P_REG_ADDR_ACK;
          end else begin
            c.op           = OP_WARN;
            c.warning_code = WARN_REG_ADDR;
            phase_next     = P_IDLE;
          end
        end
        P_WAIT_OP: begin
          if (ev.kind == KIND_REPEAT) begin
            reading_next = 1'b1;
            count_next   = '0;
            phase_next   = P_READ_ADDR;
          end else if (ev.kind == KIND_STOP) begin
            reading_next = 1'b1;
            count_next   = '0;
            phase_next   = P_IDLE;
          end else if (ev.kind == KIND_DATA_WRITE) begin
            // first write byte always lands at slot zero
            reading_next    = 1'b0;
            push            = 1'b1;
            c.op            = OP_STORE;
            c.count         = '0;
            count_next      = CNT_W'(1);
            data_stamp_next = ev.start_stamp;
            phase_next      = P_WRITE_DATA_ACK;
          end else begin
            push           = 1'b1;
            c.op           = OP_WARN;
            c.warning_code = WARN_WAIT_OP;
            phase_next     = P_IDLE;
          end
        end
        P_READ_ADDR: begin
          if (ev.kind == KIND_ADDR_READ) begin
            count_next      = '0;
            data_stamp_next = ev.start_stamp;
            phase_next      = P_READ_ADDR_ACK;
          end else begin
            push           = 1'b1;
            c.op           = OP_WARN;
            c.warning_code = WARN_ADDR_READ;
            phase_next     = P_IDLE;
          end
        end
        P_READ_DATA: begin
          if (ev.kind == KIND_DATA_READ) begin
            if (room) begin
              push       = 1'b1;
              c.op       = OP_STORE;
              count_next = count + 1'b1;
            end
          end else if (ev.kind == KIND_STOP) begin
            push          = 1'b1;
            c.op          = OP_DUMP;
            c.is_read     = reading;
            c.reg_address = reg_addr;
            c.got_kind    = '0;
            c.stamp_a     = addr_stamp;
            c.stamp_b     = data_stamp;
            phase_next    = P_IDLE;
          end else if (ev.kind != KIND_ACK && ev.kind != KIND_NACK) begin
            phase_next = P_IDLE;
          end
        end
        P_WRITE_DATA: begin
          if (ev.kind == KIND_DATA_WRITE) begin
            if (room) begin
              push       = 1'b1;
              c.op       = OP_STORE;
              count_next = count + 1'b1;
            end
            phase_next = P_WRITE_DATA_ACK;
          end else if (ev.kind == KIND_STOP) begin
            push          = 1'b1;
            c.op          = OP_DUMP;
            c.is_read     = reading;
            c.reg_address = reg_addr;
            c.got_kind    = '0;
            c.stamp_a     = addr_stamp;
            c.stamp_b     = data_stamp;
            phase_next    = P_IDLE;
          end else begin
            push           = 1'b1;
            c.op           = OP_WARN;
            c.warning_code = WARN_WRITE_BURST;
            phase_next     = P_IDLE;
          end
        end
        default: begin
          phase_next = P_IDLE;
        end
      endcase
    end
  end

  // transaction state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= P_IDLE;
      reg_addr   <= '0;
      reading    <= 1'b0;
      count      <= '0;
      addr_stamp <= '0;
      data_stamp <= '0;
    end else begin
      phase      <= phase_next;
      reg_addr   <= reg_addr_next;
      reading    <= reading_next;
      count      <= count_next;
      addr_stamp <= addr_stamp_next;
      data_stamp <= data_stamp_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tid_back.sv
// Back end: executes commands, holds the byte buffer and drives the record channel.
`default_nettype none

module tid_back
  import tid_pkg::*;
#(
  parameter int BUFFER_DEPTH = 32,
  parameter int STAMP_WIDTH  = 48,
  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1,
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1),
  localparam int CMD_W = cmd_width(CNT_W, STAMP_WIDTH)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CMD_W-1:0] cmd,
  input  wire logic             cmd_valid,
  output logic                  pop,
  tid_rec_if.source             rec
);

  typedef struct packed {
    op_t                    op;
    logic                   is_read;
    logic [7:0]             reg_address;
    logic [7:0]             data;
    logic [CNT_W-1:0]       count;
    warn_code_t             warning_code;
    kind_t                  got_kind;
    logic [STAMP_WIDTH-1:0] stamp_a;
    logic [STAMP_WIDTH-1:0] stamp_b;
    logic [STAMP_WIDTH-1:0] stamp_c;
  } cmd_t;

  typedef struct packed {
    rec_kind_t              record_kind;
    logic                   is_read;
    logic [7:0]             reg_address;
    logic [7:0]             out_byte;
    logic [IDX_W-1:0]       byte_index;
    logic [CNT_W-1:0]       byte_count;
    warn_code_t             warning_code;
    kind_t                  got_kind;
    logic [STAMP_WIDTH-1:0] span_start;
    logic [STAMP_WIDTH-1:0] span_end;
    logic                   last;
  } rec_t;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_EMIT = 2'd2;
  localparam logic [1:0] B_END  = 2'd3;

  logic [7:0]       mem [BUFFER_DEPTH];
  logic [7:0]       rdata;
  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             out_v;
  rec_t             out_r, rec_next;
  logic             free;
  logic             load;
  logic             store_en;
  cmd_t             c;

  assign c    = cmd;
  assign free = !out_v || rec.ready;

  // byte buffer, registered read
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[c.count[IDX_W-1:0]] <= c.data;
    end
    rdata <= mem[idx[IDX_W-1:0]];
  end

  // command sequencer
  always_comb begin
    state_next = state;
    idx_next   = idx;
    load       = 1'b0;
    pop        = 1'b0;
    store_en   = 1'b0;
    rec_next   = '0;
    rec_next.is_read     = c.is_read;
    rec_next.reg_address = c.reg_address;
    rec_next.span_start  = c.stamp_a;
    rec_next.span_end    = c.stamp_c;

    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          case (c.op)
            OP_ADDR, OP_WARN: begin
              if (free) begin
                load                  = 1'b1;
                pop                   = 1'b1;
                rec_next.record_kind  = (c.op == OP_ADDR) ? REC_ADDR : REC_WARN;
                rec_next.warning_code = c.warning_code;
                rec_next.got_kind     = c.got_kind;
                rec_next.last         = 1'b1;
              end
            end
            OP_STORE: begin
              store_en = 1'b1;
              pop      = 1'b1;
            end
            default: begin
              idx_next   = '0;
              state_next = (c.count == '0) ? B_END : B_READ;
            end
          endcase
        end
      end
      B_READ: begin
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (free) begin
          load                 = 1'b1;
          rec_next.record_kind = REC_DATA;
          rec_next.out_byte    = rdata;
          rec_next.byte_index  = idx[IDX_W-1:0];
          rec_next.byte_count  = c.count;
          rec_next.span_start  = c.stamp_b;
          idx_next             = idx + 1'b1;
          state_next           = (idx_next == c.count) ? B_END : B_READ;
        end
      end
      B_END: begin
        if (free) begin
          load                 = 1'b1;
          pop                  = 1'b1;
          rec_next.record_kind = REC_END;
          rec_next.byte_count  = c.count;
          rec_next.last        = 1'b1;
          state_next           = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      idx   <= '0;
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load) begin
        out_v <= 1'b1;
      end else if (rec.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= rec_next;
    end
  end

  assign rec.valid        = out_v;
  assign rec.record_kind  = out_r.record_kind;
  assign rec.is_read      = out_r.is_read;
  assign rec.reg_address  = out_r.reg_address;
  assign rec.out_byte     = out_r.out_byte;
  assign rec.byte_index   = out_r.byte_index;
  assign rec.byte_count   = out_r.byte_count;
  assign rec.warning_code = out_r.warning_code;
  assign rec.got_kind     = out_r.got_kind;
  assign rec.span_start   = out_r.span_start;
  assign rec.span_end     = out_r.span_end;
  assign rec.last         = out_r.last;

  a_dump_has_cmd: assert property (@(posedge clk) disable iff (rst)
    state != B_IDLE |-> (cmd_valid && c.op == OP_DUMP))
    else $error("dump running without a dump command at the queue head");
  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    state == B_EMIT |-> idx < c.count)
    else $error("dump index past stored count");
  a_store_in_range: assert property (@(posedge clk) disable iff (rst)
    store_en |-> c.count < CNT_W'(BUFFER_DEPTH))
    else $error("byte store beyond buffer depth");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_v && !rec.ready) |=> ($stable(out_r) && out_v))
    else $error("pending record overwritten");

endmodule

`default_nettype wire

### hw/rtl/tpm_i2c_transaction_decoder_unit.sv
// Top level of the TPM I2C transaction decoder: front, command queue and back.
`default_nettype none

// Decodes TPM register transactions from a stream of I2C events (kind, byte,
// start and end sample stamps) into records: a register-address record when the
// address byte is seen, a warning on some misplaced events, and at the closing
// STOP one data-byte record per buffered byte followed by a transaction-end
// record (last set). The front takes one event per cycle while the four-entry
// command queue has room. The back retires a register-address, warning or
// byte-store command from the queue head; a STOP dump passes through a read
// state and an emit state per buffered byte, the read state serving the
// registered read port of the byte buffer, then an end state. Bytes past
// BUFFER_DEPTH are dropped and the reported count holds at BUFFER_DEPTH. A
// one-record output register lets the back run ahead of a stalled consumer by
// one record; the front keeps accepting events until the queue fills.
module tpm_i2c_transaction_decoder_unit
  import tid_pkg::*;
#(
  parameter int BUFFER_DEPTH = 32,
  parameter int STAMP_WIDTH  = 48
) (
  input  wire logic clk,
  input  wire logic rst,
  tid_ev_if.sink    ev,
  tid_rec_if.source rec
);

  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int CMD_W = cmd_width(CNT_W, STAMP_WIDTH);

  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  logic [CMD_W-1:0] cmd_in;
  logic [CMD_W-1:0] cmd_head;

  tid_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .STAMP_WIDTH  (STAMP_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .ev     (ev),
    .q_full (q_full),
    .push   (push),
    .cmd    (cmd_in)
  );

  tid_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd_in),
    .pop       (pop),
    .head      (cmd_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  tid_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .STAMP_WIDTH  (STAMP_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_valid (!q_empty),
    .pop       (pop),
    .rec       (rec)
  );

endmodule

`default_nettype wire

### tb/tb_tpm_i2c_transaction_decoder_unit.sv
// Self-checking testbench for the TPM I2C transaction decoder with a built-in record predictor.
`timescale 1ns / 1ps

module tb_tpm_i2c_transaction_decoder_unit;
  import tid_pkg::*;

  localparam int BUFFER_DEPTH = 32;
  localparam int STAMP_W      = 48;
  localparam int IDX_W        = 5;
  localparam int CNT_W        = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 12;

  typedef logic [STAMP_W-1:0] stamp_t;
  localparam stamp_t STAMP_MAX = '1;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    stamp_t     start_stamp;
    stamp_t     end_stamp;
  } i2c_event_t;

  typedef struct packed {
    rec_kind_t        record_kind;
    logic             is_read;
    logic [7:0]       reg_address;
    logic [7:0]       out_byte;
    logic [IDX_W-1:0] byte_index;
    logic [CNT_W-1:0] byte_count;
    warn_code_t       warning_code;
    kind_t            got_kind;
    stamp_t           span_start;
    stamp_t           span_end;
    logic             last;
  } record_t;

  // Transaction phases of the decoder
  typedef enum logic [3:0] {
    PH_IDLE, PH_ADDR_WRITE, PH_ADDR_ACK, PH_REG_ADDR, PH_REG_ADDR_ACK, PH_WAIT_OP,
    PH_READ_ADDR, PH_READ_ADDR_ACK, PH_READ_DATA, PH_WRITE_DATA, PH_WRITE_DATA_ACK
  } phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tid_ev_if #(.STAMP_WIDTH(STAMP_W)) ev_ch ();
  tid_rec_if #(.STAMP_WIDTH(STAMP_W), .IDX_W(IDX_W), .CNT_W(CNT_W)) rec_ch ();

  tpm_i2c_transaction_decoder_unit #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .STAMP_WIDTH (STAMP_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .ev (ev_ch.sink),
    .rec(rec_ch.source)
  );

  // Block inputs, known from time zero
  logic       ev_valid  = 1'b0;
  i2c_event_t ev_bus    = '0;
  logic       rec_ready = 1'b0;

  assign ev_ch.valid       = ev_valid;
  assign ev_ch.kind        = ev_bus.kind;
  assign ev_ch.data_byte   = ev_bus.data_byte;
  assign ev_ch.start_stamp = ev_bus.start_stamp;
  assign ev_ch.end_stamp   = ev_bus.end_stamp;
  assign rec_ch.ready      = rec_ready;

  i2c_event_t pending_events[$];
  record_t    expected_records[$];

  int errors         = 0;
  int queued_items   = 0;
  int send_idle_pct  = 26;
  int recv_idle_pct  = 59;
  int stall_requests = 0;
  int stalls_begun   = 0;
  int hold_left      = 0;

  // Predicted decoder state
  phase_e     phase_q    = PH_IDLE;
  logic [7:0] reg_addr   = '0;
  logic       rd_flag    = 1'b0;
  logic [7:0] byte_store [BUFFER_DEPTH];
  int         stored     = 0;
  stamp_t     addr_stamp = '0;
  stamp_t     data_stamp = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic add_record(input rec_kind_t k, input logic rd, input logic [7:0] ra,
                            input logic [7:0] ob, input logic [IDX_W-1:0] idx, input int cnt,
                            input warn_code_t wc, input kind_t gk, input stamp_t s0,
                            input stamp_t s1, input logic lst);
    record_t r;
    r.record_kind  = k;
    r.is_read      = rd;
    r.reg_address  = ra;
    r.out_byte     = ob;
    r.byte_index   = idx;
    r.byte_count   = CNT_W'(cnt);
    r.warning_code = wc;
    r.got_kind     = gk;
    r.span_start   = s0;
    r.span_end     = s1;
    r.last         = lst;
    expected_records.push_back(r);
  endtask

  // Warning spans only the offending event and drops the machine to idle
  task automatic raise_warning(input warn_code_t wc, input i2c_event_t e);
    add_record(REC_WARN, 1'b0, '0, '0, '0, 0, wc, e.kind, e.start_stamp, e.end_stamp, 1'b1);
    phase_q = PH_IDLE;
  endtask

  // Bytes past the buffer depth are dropped, count holds
  function automatic void keep_byte(input logic [7:0] b);
    if (stored < BUFFER_DEPTH) begin
      byte_store[stored] = b;
      stored++;
    end
  endfunction

  // STOP closing a burst: one record per buffered byte, then the end record
  task automatic dump_bytes(input stamp_t es);
    for (int i = 0; i < stored; i++) begin
      add_record(REC_DATA, rd_flag, reg_addr, byte_store[i], IDX_W'(i), stored, '0, '0,
                 data_stamp, es, 1'b0);
    end
    add_record(REC_END, rd_flag, reg_addr, '0, '0, stored, '0, '0, addr_stamp, es, 1'b1);
    phase_q = PH_IDLE;
  endtask

  task automatic decode_event(input i2c_event_t e);
    if (e.kind == KIND_BITS) return;
    case (phase_q)
      PH_IDLE: begin
        if (e.kind == KIND_START) begin
          phase_q = PH_ADDR_WRITE;
          stored  = 0;
        end
      end
      PH_ADDR_WRITE: begin
        if (e.kind == KIND_ADDR_WRITE) begin
          addr_stamp = e.start_stamp;
          phase_q    = PH_ADDR_ACK;
        end else begin
          phase_q = PH_IDLE;
        end
      end
      // acknowledge phases ignore anything but ACK and NACK
      PH_ADDR_ACK, PH_REG_ADDR_ACK, PH_READ_ADDR_ACK, PH_WRITE_DATA_ACK: begin
        if (e.kind == KIND_NACK) begin
          phase_q = PH_IDLE;
        end else if (e.kind == KIND_ACK) begin
          case (phase_q)
            PH_ADDR_ACK:      phase_q = PH_REG_ADDR;
            PH_REG_ADDR_ACK:  phase_q = PH_WAIT_OP;
            PH_READ_ADDR_ACK: phase_q = PH_READ_DATA;
            default:          phase_q = PH_WRITE_DATA;
          endcase
        end
      end
      PH_REG_ADDR: begin
        if (e.kind == KIND_DATA_WRITE) begin
          reg_addr = e.data_byte;
          add_record(REC_ADDR, 1'b0, e.data_byte, '0, '0, 0, '0, '0, addr_stamp, e.end_stamp,
                     1'b1);
          phase_q = PH_REG_ADDR_ACK;
        end else begin
          raise_warning(WARN_REG_ADDR, e);
        end
      end
      PH_WAIT_OP: begin
        if (e.kind == KIND_REPEAT) begin
          rd_flag = 1'b1;
          stored  = 0;
          phase_q = PH_READ_ADDR;
        end else if (e.kind == KIND_STOP) begin
          // stop right after the register address: no records
          rd_flag = 1'b1;
          stored  = 0;
          phase_q = PH_IDLE;
        end else if (e.kind == KIND_DATA_WRITE) begin
          rd_flag = 1'b0;
          stored  = 0;
          keep_byte(e.data_byte);
          data_stamp = e.start_stamp;
          phase_q    = PH_WRITE_DATA_ACK;
        end else begin
          raise_warning(WARN_WAIT_OP, e);
        end
      end
      PH_READ_ADDR: begin
        if (e.kind == KIND_ADDR_READ) begin
          stored     = 0;
          data_stamp = e.start_stamp;
          phase_q    = PH_READ_ADDR_ACK;
        end else begin
          raise_warning(WARN_ADDR_READ, e);
        end
      end
      PH_READ_DATA: begin
        if (e.kind == KIND_DATA_READ) keep_byte(e.data_byte);
        else if (e.kind == KIND_STOP) dump_bytes(e.end_stamp);
        else if (e.kind != KIND_ACK && e.kind != KIND_NACK) phase_q = PH_IDLE;
      end
      PH_WRITE_DATA: begin
        if (e.kind == KIND_DATA_WRITE) begin
          keep_byte(e.data_byte);
          phase_q = PH_WRITE_DATA_ACK;
        end else if (e.kind == KIND_STOP) begin
          dump_bytes(e.end_stamp);
        end else begin
          raise_warning(WARN_WRITE_BURST, e);
        end
      end
      default: phase_q = PH_IDLE;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Event driver
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : event_driver
    i2c_event_t offered;
    if (rst) begin
      ev_valid <= 1'b0;
    end else begin
      if (ev_valid && ev_ch.ready) decode_event(ev_bus);
      if (!ev_valid || ev_ch.ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_events.pop_front();
          ev_bus   <= offered;
          ev_valid <= 1'b1;
        end else begin
          ev_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Record monitor and checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : record_monitor
    record_t seen;
    record_t want;
    if (rst) begin
      rec_ready <= 1'b0;
    end else begin
      if (rec_ch.valid && rec_ready) begin
        seen.record_kind  = rec_ch.record_kind;
        seen.is_read      = rec_ch.is_read;
        seen.reg_address  = rec_ch.reg_address;
        seen.out_byte     = rec_ch.out_byte;
        seen.byte_index   = rec_ch.byte_index;
        seen.byte_count   = rec_ch.byte_count;
        seen.warning_code = rec_ch.warning_code;
        seen.got_kind     = rec_ch.got_kind;
        seen.span_start   = rec_ch.span_start;
        seen.span_end     = rec_ch.span_end;
        seen.last         = rec_ch.last;
        if (expected_records.size() == 0) begin
          $error("unexpected record: record_kind %0d", seen.record_kind);
          errors++;
        end else begin
          want = expected_records.pop_front();
          if (seen.record_kind !== want.record_kind) begin
            $error("record_kind: expected %0d, got %0d", want.record_kind, seen.record_kind);
            errors++;
          end
          if (seen.is_read !== want.is_read) begin
            $error("is_read: expected %0d, got %0d", want.is_read, seen.is_read);
            errors++;
          end
          if (seen.reg_address !== want.reg_address) begin
            $error("reg_address: expected %0h, got %0h", want.reg_address, seen.reg_address);
            errors++;
          end
          if (seen.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, seen.out_byte);
            errors++;
          end
          if (seen.byte_index !== want.byte_index) begin
            $error("byte_index: expected %0d, got %0d", want.byte_index, seen.byte_index);
            errors++;
          end
          if (seen.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count, seen.byte_count);
            errors++;
          end
          if (seen.warning_code !== want.warning_code) begin
            $error("warning_code: expected %0d, got %0d", want.warning_code,
                   seen.warning_code);
            errors++;
          end
          if (seen.got_kind !== want.got_kind) begin
            $error("got_kind: expected %0d, got %0d", want.got_kind, seen.got_kind);
            errors++;
          end
          if (seen.span_start !== want.span_start) begin
            $error("span_start: expected %0h, got %0h", want.span_start, seen.span_start);
            errors++;
          end
          if (seen.span_end !== want.span_end) begin
            $error("span_end: expected %0h, got %0h", want.span_end, seen.span_end);
            errors++;
          end
          if (seen.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, seen.last);
            errors++;
          end
        end
      end
      // long hold-off on request, otherwise random backpressure
      if (stall_requests != stalls_begun) begin
        stalls_begun++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rec_ready <= 1'b0;
      end else begin
        rec_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic stamp_t rand_stamp();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(7))
      0:       return '0;
      1:       return STAMP_MAX;
      default: return r[STAMP_W-1:0];
    endcase
  endfunction

  task automatic add_event(input kind_t k, input logic [7:0] b, input stamp_t ss,
                           input stamp_t es);
    i2c_event_t e;
    e.kind        = k;
    e.data_byte   = b;
    e.start_stamp = ss;
    e.end_stamp   = es;
    pending_events.push_back(e);
    if (k != KIND_BITS) queued_items++;
  endtask

  // One register transaction with random content; a negative length picks one
  task automatic push_txn(input int forced_len);
    int    nbytes;
    bit    reading;
    kind_t seq[$];
    if (forced_len >= 0) nbytes = forced_len;
    else if ($urandom_range(9) == 0) nbytes = $urandom_range(35, 31);
    else nbytes = $urandom_range(4);
    reading = 1'($urandom_range(1));
    seq = {KIND_START, KIND_ADDR_WRITE, KIND_ACK, KIND_DATA_WRITE, KIND_ACK};
    if (reading) begin
      seq.push_back(KIND_REPEAT);
      seq.push_back(KIND_ADDR_READ);
      seq.push_back(KIND_ACK);
      repeat (nbytes) begin
        seq.push_back(KIND_DATA_READ);
        if ($urandom_range(2) != 0) seq.push_back($urandom_range(1) ? KIND_ACK : KIND_NACK);
      end
    end else begin
      repeat (nbytes) begin
        seq.push_back(KIND_DATA_WRITE);
        seq.push_back(KIND_ACK);
      end
    end
    seq.push_back(KIND_STOP);
    // some sequences get one event replaced by an arbitrary kind
    if (forced_len < 0 && $urandom_range(4) == 0) begin
      seq[$urandom_range(seq.size() - 1)] = kind_t'($urandom_range(15));
    end
    // occasional line noise ahead of the start
    if (forced_len < 0 && $urandom_range(7) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        add_event(kind_t'($urandom_range(15)), 8'($urandom), rand_stamp(), rand_stamp());
      end
    end
    foreach (seq[i]) begin
      if ($urandom_range(11) == 0) add_event(KIND_BITS, 8'($urandom), rand_stamp(), rand_stamp());
      add_event(seq[i], 8'($urandom), rand_stamp(), rand_stamp());
    end
  endtask

  task automatic push_random_items(input int count);
    int target;
    target = queued_items + count;
    while (queued_items < target) push_txn(-1);
  endtask

  // Sender pause: nothing left to send and every predicted record seen
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_events.size() != 0 || ev_valid || expected_records.size() != 0);
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ignored in idle: bit event and an undefined kind
    add_event(KIND_BITS, 8'hFF, STAMP_MAX, STAMP_MAX);
    add_event(kind_t'(4'hA), 8'h00, '0, '0);
    // write of one byte, stray data read in an ack phase, extreme stamps
    add_event(KIND_START, 8'h00, '0, '0);
    add_event(KIND_ADDR_WRITE, 8'h00, '0, 48'd1);
    add_event(KIND_DATA_READ, 8'h5A, rand_stamp(), rand_stamp());
    add_event(KIND_ACK, 8'h00, rand_stamp(), rand_stamp());
    add_event(KIND_DATA_WRITE, 8'hFF, STAMP_MAX, STAMP_MAX);
    add_event(KIND_ACK, 8'h00, rand_stamp(), rand_stamp());
    add_event(KIND_DATA_WRITE, 8'h00, '0, STAMP_MAX);
    add_event(KIND_ACK, 8'h00, rand_stamp(), rand_stamp());
    add_event(KIND_STOP, 8'h00, rand_stamp(), STAMP_MAX);
    // read of one byte ended by NACK
    add_event(KIND_START, 8'h00, rand_stamp(), rand_stamp());
    add_event(KIND_ADDR_WRITE, 8'h00, STAMP_MAX, rand_stamp());
    add_event(KIND_ACK, 8'h00, rand_stamp(), rand_stamp());
    add_event(KIND_DATA_WRITE, 8'h00, rand_stamp(), '0);
    add_event(KIND_ACK, 8'h00, rand_stamp(), rand_stamp());
    add_event(KIND_REPEAT, 8'h00, rand_stamp(), rand_stamp());
    add_event(KIND_ADDR_READ, 8'h00, '0, rand_stamp());
    add_event(KIND_ACK, 8'h00, rand_stamp(), rand_stamp());
    add_event(KIND_DATA_READ, 8'hFF, rand_stamp(), rand_stamp());
    add_event(KIND_NACK, 8'h00, rand_stamp(), rand_stamp());
    add_event(KIND_STOP, 8'h00, rand_stamp(), rand_stamp());
    // undefined kind where the register address byte belongs
    add_event(KIND_START, 8'h00, rand_stamp(), rand_stamp());
    add_event(KIND_ADDR_WRITE, 8'h00, rand_stamp(), rand_stamp());
    add_event(KIND_ACK, 8'h00, rand_stamp(), rand_stamp());
    add_event(kind_t'(4'hF), 8'hA5, STAMP_MAX, '0);

    push_random_items(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 59;
    recv_idle_pct = 26;
    push_random_items(PHASE_ITEMS);
    wait_drained();

    // no idling; long receiver hold while warnings and a long burst back up
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    stall_requests = stall_requests + 1;
    repeat (2) begin
      add_event(KIND_START, 8'($urandom), rand_stamp(), rand_stamp());
      add_event(KIND_ADDR_WRITE, 8'($urandom), rand_stamp(), rand_stamp());
      add_event(KIND_ACK, 8'($urandom), rand_stamp(), rand_stamp());
      add_event(KIND_NACK, 8'($urandom), rand_stamp(), rand_stamp());
    end
    // read burst past the buffer depth, bytes back to back
    add_event(KIND_START, 8'($urandom), rand_stamp(), rand_stamp());
    add_event(KIND_ADDR_WRITE, 8'($urandom), rand_stamp(), rand_stamp());
    add_event(KIND_ACK, 8'($urandom), rand_stamp(), rand_stamp());
    add_event(KIND_DATA_WRITE, 8'($urandom), rand_stamp(), rand_stamp());
    add_event(KIND_ACK, 8'($urandom), rand_stamp(), rand_stamp());
    add_event(KIND_REPEAT, 8'($urandom), rand_stamp(), rand_stamp());
    add_event(KIND_ADDR_READ, 8'($urandom), rand_stamp(), rand_stamp());
    add_event(KIND_ACK, 8'($urandom), rand_stamp(), rand_stamp());
    repeat (BUFFER_DEPTH + 2) begin
      add_event(KIND_DATA_READ, 8'($urandom), rand_stamp(), rand_stamp());
    end
    add_event(KIND_STOP, 8'($urandom), rand_stamp(), rand_stamp());
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
